>>> sv/aip_pkg.sv
// Package for the ASCII integer parser: request types, parse phases, codes
// and the digit helpers used by the parse core.
// Depends on nothing.
package aip_pkg;

	// Width of the accumulator; the result field is always 64 bits.
	localparam int VALUE_WIDTH = 64;

	// Parse phases of one string.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SIGNED,
		PH_AUTOZERO,
		PH_DIGITS,
		PH_STOPPED
	} phase_t;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_MINUS = 2'd2;

	// Register indexes on the configuration port.
	localparam logic REG_RADIX  = 1'b0;
	localparam logic REG_SIGNED = 1'b1;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_X     = 8'h78;

	// Radix codes.
	localparam logic [4:0] RADIX_AUTO = 5'd0;
	localparam logic [4:0] RADIX_2    = 5'd2;
	localparam logic [4:0] RADIX_8    = 5'd8;
	localparam logic [4:0] RADIX_10   = 5'd10;
	localparam logic [4:0] RADIX_16   = 5'd16;

	// Reset values of the registers.
	localparam logic [4:0] RADIX_RESET  = RADIX_10;
	localparam logic       SIGNED_RESET = 1'b1;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
	} res_t;

	typedef struct packed {
		logic [4:0] radix_mode;
		logic       signed_mode;
	} cfg_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	// Digit value of a character in a radix; ok is low when it is no digit there.
	function automatic digit_t digit_of(input logic [7:0] c, input logic [4:0] radix);
		digit_t d;
		logic [7:0] raw;
		logic hit;
		hit = 1'b1;
		raw = '0;
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			raw = c - CH_ZERO;
		end else if (c inside {[CH_LA:CH_LF]}) begin
			raw = c - CH_LA + 8'd10;
		end else if (c inside {[CH_UA:CH_UF]}) begin
			raw = c - CH_UA + 8'd10;
		end else begin
			hit = 1'b0;
		end
		d.ok = hit && (radix inside {RADIX_2, RADIX_8, RADIX_10, RADIX_16})
			&& (raw < {3'b000, radix});
		d.val = raw[3:0];
		return d;
	endfunction

	// Accumulator times the radix, as shifts and one add for base ten.
	function automatic logic [VALUE_WIDTH-1:0] scale(input logic [VALUE_WIDTH-1:0] acc,
			input logic [4:0] radix);
		logic [VALUE_WIDTH-1:0] r;
		case (radix)
			RADIX_2:  r = acc << 1;
			RADIX_8:  r = acc << 3;
			RADIX_10: r = (acc << 3) + (acc << 1);
			RADIX_16: r = acc << 4;
			default:  r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/ascii_integer_parser.sv
// Top level of the ASCII integer parser: input stage, parse core, result
// register and configuration port. Depends on aip_pkg, aip_cfg and aip_core.
//
//   Channel  Signals                            Moves
//   char     char_valid, char_stall, char_data  one character and end mark
//   res      res_valid, res_stall, res_data     one parsed value and status
//   cfg      psel, penable, pwrite, paddr, ...  register writes and reads
//
// One character is taken in every cycle while char_stall is low; the parse core
// updates its state from the input stage character whenever the stage moves on.
// The result register takes the result when the character ending the string moves on.
// char_stall rises only when a string end waits in the stage while a result
// is still held by res_stall. Reset clears the stage, the parse state and
// the result valid, and loads the register reset values.
module ascii_integer_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           char_valid,
	output logic           char_stall,
	input  aip_pkg::char_t char_data,
	output logic           res_valid,
	input  logic           res_stall,
	output aip_pkg::res_t  res_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import aip_pkg::*;

	char_t item_s1;
	logic  valid_s1;
	logic  adv;
	logic  fin;
	logic  char_take;
	res_t  core_res;
	res_t  res_q;
	logic  res_valid_q;
	cfg_t  cfg;

	aip_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	aip_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.en     (adv),
		.cfg    (cfg),
		.res    (core_res),
		.fin    (fin)
	);

	// The stage moves on unless it ends a string and the result slot is held.
	assign adv        = valid_s1 && !(fin && res_valid_q && res_stall);
	assign char_stall = valid_s1 && !adv;
	assign char_take  = char_valid && !char_stall;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_take) begin
			item_s1 <= char_data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && fin) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin) begin
			res_q <= core_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

>>> sv/aip_cfg.sv
// Configuration registers of the ASCII integer parser on an APB-style port.
// Depends on aip_pkg.
module aip_cfg (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output aip_pkg::cfg_t cfg
);
	import aip_pkg::*;

	logic [4:0] radix_q;
	logic       signed_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Register writes in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= RADIX_RESET;
			signed_q <= SIGNED_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_RADIX) begin
				radix_q <= pwdata[4:0];
			end else begin
				signed_q <= pwdata[0];
			end
		end
	end

	// Read back of the selected register.
	always_comb begin
		if (paddr[2] == REG_RADIX) begin
			prdata = {27'd0, radix_q};
		end else begin
			prdata = {31'd0, signed_q};
		end
	end

	assign cfg.radix_mode  = radix_q;
	assign cfg.signed_mode = signed_q;

endmodule

>>> sv/aip_core.sv
// Parse state and per-character update of the ASCII integer parser.
// Depends on aip_pkg.
module aip_core (
	input  logic           clk,
	input  logic           arst_n,
	input  aip_pkg::char_t item,
	input  logic           en,
	input  aip_pkg::cfg_t  cfg,
	output aip_pkg::res_t  res,
	output logic           fin
);
	import aip_pkg::*;

	phase_t                 phase_q, phase_n;
	logic [VALUE_WIDTH-1:0] acc_q, acc_n;
	logic                   neg_q, neg_n;
	logic [4:0]             radix_q, radix_n;
	logic [1:0]             err_q, err_n;
	logic                   first;
	logic                   do_digit;
	logic                   first_octal;
	logic [4:0]             first_radix;
	digit_t                 dig;

	assign fin = item.last || (item.ch == CH_NUL);

	// Radix chosen by the first character after spaces and sign.
	assign first_octal = (cfg.radix_mode == RADIX_AUTO) && (item.ch == CH_ZERO);
	assign first_radix = (cfg.radix_mode == RADIX_AUTO) ? RADIX_10 : cfg.radix_mode;

	// Next state for the character in the stage, and the result it would give.
	always_comb begin
		phase_n  = phase_q;
		acc_n    = acc_q;
		neg_n    = neg_q;
		radix_n  = radix_q;
		err_n    = err_q;
		first    = 1'b0;
		do_digit = 1'b0;
		if (item.ch != CH_NUL) begin
			case (phase_q)
				PH_IDLE: begin
					if (item.ch == CH_MINUS) begin
						if (cfg.signed_mode) begin
							neg_n   = 1'b1;
							phase_n = PH_SIGNED;
						end else begin
							err_n   = ST_MINUS;
							phase_n = PH_STOPPED;
						end
					end else if (item.ch != CH_SPACE) begin
						first = 1'b1;
					end
				end
				PH_SIGNED: first = 1'b1;
				PH_AUTOZERO: begin
					if (item.ch == CH_X) begin
						radix_n = RADIX_16;
						phase_n = PH_DIGITS;
					end else begin
						do_digit = 1'b1;
					end
				end
				PH_DIGITS: do_digit = 1'b1;
				default: ;
			endcase
		end
		if (first) begin
			if (first_octal) begin
				radix_n = RADIX_8;
				phase_n = PH_AUTOZERO;
			end else begin
				radix_n  = first_radix;
				do_digit = 1'b1;
			end
		end
		dig = digit_of(item.ch, radix_n);
		if (do_digit) begin
			if (dig.ok) begin
				acc_n   = scale(acc_q, radix_n) + VALUE_WIDTH'(dig.val);
				phase_n = PH_DIGITS;
			end else begin
				phase_n = PH_STOPPED;
			end
		end

		res.value  = '0;
		res.status = ST_OK;
		if (phase_n == PH_IDLE) begin
			res.status = ST_EMPTY;
		end else if (err_n != ST_OK) begin
			res.status = err_n;
		end else begin
			res.value = 64'(neg_n ? -acc_n : acc_n);
		end
	end

	// State register; the end of a string returns it to its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			radix_q <= RADIX_AUTO;
			err_q   <= ST_OK;
		end else if (en) begin
			if (fin) begin
				phase_q <= PH_IDLE;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				radix_q <= RADIX_AUTO;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				radix_q <= radix_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

>>> sv/aip_checker.sv
// Port checks for the ASCII integer parser and the bind that attaches them.
// Depends on aip_pkg and on the ascii_integer_parser port list.
module aip_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_stall,
	input aip_pkg::res_t  res_data,
	input logic           psel,
	input logic           penable,
	input logic           pready
);
	import aip_pkg::*;

	// A held result keeps its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_data))
		else $error("result changed while stalled");

	// Only the three defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.status == ST_OK || res_data.status == ST_EMPTY
			|| res_data.status == ST_MINUS))
		else $error("undefined status code");

	// A failed parse carries a zero value.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status != ST_OK |-> res_data.value == 64'd0)
		else $error("nonzero value with error status");

	// The register port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("register access stalled");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (.*);

>>> dv/ascii_integer_parser_tb.sv
`timescale 1ns / 100ps
// Testbench for ascii_integer_parser: streams character requests, predicts each
// parsed result in a small tracker class and compares it with the block output.
// Depends on aip_pkg and the ascii_integer_parser top level.
module ascii_integer_parser_tb;
	import aip_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 400;
	localparam int PHASES = 12;
	localparam int PER_PHASE = 86;

	// Tracks the parse state of the string in flight and the results it owes.
	class parse_tracker;
		phase_t     phase;
		logic [63:0] acc;
		bit         neg;
		logic [4:0] act_radix;
		logic [1:0] err;
		logic [4:0] radix_cfg;
		bit         signed_cfg;
		res_t       expected_results[$];
		int         errors;
		int         n_chars;
		int         n_results;

		function new();
			radix_cfg = RADIX_RESET;
			signed_cfg = SIGNED_RESET;
			errors = 0;
			n_chars = 0;
			n_results = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_IDLE;
			acc = '0;
			neg = 1'b0;
			act_radix = '0;
			err = ST_OK;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void write_reg(logic idx, logic [31:0] data);
			if (idx == REG_RADIX) begin
				radix_cfg = data[4:0];
			end else begin
				signed_cfg = data[0];
			end
		endfunction

		// Value of a character as a digit of the radix, or -1.
		function int digit_value(logic [7:0] c, logic [4:0] r);
			int d;
			d = -1;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = int'(c) - int'(CH_ZERO);
			end else if (c >= CH_LA && c <= CH_LF) begin
				d = int'(c) - int'(CH_LA) + 10;
			end else if (c >= CH_UA && c <= CH_UF) begin
				d = int'(c) - int'(CH_UA) + 10;
			end
			if (!(r == RADIX_2 || r == RADIX_8 || r == RADIX_10 || r == RADIX_16))
				return -1;
			if (d >= int'(r))
				return -1;
			return d;
		endfunction

		function void take_digit(logic [7:0] c);
			int d;
			d = digit_value(c, act_radix);
			if (d < 0) begin
				phase = PH_STOPPED;
			end else begin
				acc = acc * 64'(act_radix) + 64'(d);
				phase = PH_DIGITS;
			end
		endfunction

		// First character after spaces and sign: the radix is latched here.
		function void take_first(logic [7:0] c);
			if (radix_cfg == RADIX_AUTO) begin
				if (c == CH_ZERO) begin
					act_radix = RADIX_8;
					phase = PH_AUTOZERO;
					return;
				end
				act_radix = RADIX_10;
			end else begin
				act_radix = radix_cfg;
			end
			take_digit(c);
		endfunction

		// Notes one accepted character request and queues the result it ends.
		function void take_char(char_t c);
			bit   fin;
			res_t r;
			fin = c.last || (c.ch == CH_NUL);
			n_chars++;
			if (c.ch != CH_NUL) begin
				case (phase)
					PH_IDLE: begin
						if (c.ch == CH_MINUS) begin
							if (signed_cfg) begin
								neg = 1'b1;
								phase = PH_SIGNED;
							end else begin
								err = ST_MINUS;
								phase = PH_STOPPED;
							end
						end else if (c.ch != CH_SPACE) begin
							take_first(c.ch);
						end
					end
					PH_SIGNED: take_first(c.ch);
					PH_AUTOZERO: begin
						if (c.ch == CH_X) begin
							act_radix = RADIX_16;
							phase = PH_DIGITS;
						end else begin
							take_digit(c.ch);
						end
					end
					PH_DIGITS: take_digit(c.ch);
					default: ;
				endcase
			end
			if (fin) begin
				r.value = '0;
				r.status = ST_OK;
				if (phase == PH_IDLE) begin
					r.status = ST_EMPTY;
				end else if (err != ST_OK) begin
					r.status = err;
				end else begin
					r.value = neg ? -acc : acc;
				end
				expected_results.push_back(r);
				clear();
			end
		endfunction

		// Compares one accepted result with the oldest expected one.
		function void check_result(res_t got);
			res_t want;
			n_results++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result value %h status %0d", $time,
					got.value, got.status);
				return;
			end
			want = expected_results.pop_front();
			if (got.value !== want.value) begin
				errors++;
				$display("%0t: value mismatch, expected %h actual %h", $time,
					want.value, got.value);
			end
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status mismatch, expected %0d actual %0d", $time,
					want.status, got.status);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	char_t       char_data = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	parse_tracker tracker = new();
	bit idle_on = 1'b1;
	int hold_token = 0;
	int hold_seen = 0;
	int stall_left = 0;
	int n_reg_writes = 0;

	logic [4:0] radix_plan [PHASES] = '{RADIX_2, RADIX_16, RADIX_AUTO, RADIX_10, 5'd31,
		RADIX_8, 5'd3, RADIX_AUTO, RADIX_16, RADIX_10, RADIX_2, RADIX_AUTO};

	ascii_integer_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #5 clk = ~clk;

	// Result side: check accepted results and drive stall bursts and the long hold.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			tracker.check_result(res_data);
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			stall_left = LONG_HOLD;
			res_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = int'($urandom_range(0, 16));
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Run limit.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("ascii_integer_parser test failed");
		$finish;
	end

	// One character request, after an optional idle burst.
	task automatic send_char(input char_t c);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_data <= c;
		do @(posedge clk); while (char_stall);
		tracker.take_char(c);
	endtask

	// Sends a string, ended either by last on its final character or by a NUL.
	task automatic send_text(input string s, input bit nul_end);
		char_t c;
		for (int i = 0; i < s.len(); i++) begin
			c.ch = s[i];
			c.last = !nul_end && (i == s.len() - 1);
			send_char(c);
		end
		if (nul_end) begin
			c.ch = CH_NUL;
			c.last = 1'($urandom_range(0, 1));
			send_char(c);
		end
	endtask

	// One random string: mostly well formed for the current radix, some noise.
	task automatic random_string();
		logic [7:0] q[$];
		logic [4:0] r;
		int         dr;
		int         len;
		int         d;
		bit         nul_end;
		char_t      c;
		r = tracker.radix_cfg;
		nul_end = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 3) begin
			len = int'($urandom_range(1, 6));
			repeat (len) q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
				q.push_back(CH_SPACE);
			if ($urandom_range(0, 3) == 0)
				q.push_back(CH_MINUS);
			case (r)
				RADIX_AUTO: begin
					case ($urandom_range(0, 3))
						0: dr = 10;
						1: begin
							q.push_back(CH_ZERO);
							dr = 8;
						end
						2: begin
							q.push_back(CH_ZERO);
							q.push_back(CH_X);
							dr = 16;
						end
						default: begin
							q.push_back(CH_ZERO);
							q.push_back(8'h58);
							dr = 16;
						end
					endcase
				end
				RADIX_2, RADIX_8, RADIX_10, RADIX_16: dr = int'(r);
				default: dr = 16;
			endcase
			// Long digit runs can wrap the accumulator.
			if ($urandom_range(0, 9) == 0)
				len = int'($urandom_range(12, dr == 2 ? 70 : 24));
			else
				len = int'($urandom_range(0, 8));
			repeat (len) begin
				d = int'($urandom_range(0, dr - 1));
				if (d < 10)
					q.push_back(8'(int'(CH_ZERO) + d));
				else
					q.push_back(8'(int'($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10));
			end
			// Trailing junk stops accumulation unless it is a digit; what follows is ignored.
			if ($urandom_range(0, 3) == 0) begin
				q.push_back(8'($urandom_range(1, 255)));
				q.push_back(8'(int'(CH_ZERO) + int'($urandom_range(0, 9))));
			end
		end
		if (q.size() == 0)
			nul_end = 1'b1;
		for (int i = 0; i < q.size(); i++) begin
			c.ch = q[i];
			c.last = !nul_end && (i == q.size() - 1);
			send_char(c);
		end
		if (nul_end) begin
			c.ch = CH_NUL;
			c.last = 1'($urandom_range(0, 1));
			send_char(c);
		end
	endtask

	// Stop sending and wait until every expected result is back and the block settles.
	task automatic wait_for_results();
		char_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One configuration transfer: setup cycle, then access until pready.
	task automatic apb_cycle(input bit wr, input logic idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes a register with random upper bits, then reads it back.
	task automatic set_reg(input logic idx, input logic [4:0] v);
		logic [31:0] wdata;
		logic [31:0] rdata;
		logic [4:0]  want;
		logic [4:0]  got;
		wdata = $urandom;
		if (idx == REG_RADIX)
			wdata[4:0] = v;
		else
			wdata[0] = v[0];
		apb_cycle(1'b1, idx, wdata, rdata);
		tracker.write_reg(idx, wdata);
		n_reg_writes++;
		apb_cycle(1'b0, idx, '0, rdata);
		want = (idx == REG_RADIX) ? tracker.radix_cfg : {4'b0, tracker.signed_cfg};
		got = (idx == REG_RADIX) ? rdata[4:0] : {4'b0, rdata[0]};
		if (got !== want) begin
			tracker.errors++;
			$display("%0t: register %0d readback mismatch, expected %h actual %h", $time,
				idx, want, got);
		end
	endtask

	// Main sequence: reset, directed strings, then random phases over register settings.
	initial begin
		char_t c;
		int    start_chars;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: base 10, signed.
		send_text(" -12", 1'b0);
		send_text("", 1'b1);
		send_text("  ", 1'b1);
		send_text("-", 1'b0);
		send_text("7f", 1'b1);
		c.ch = 8'hff;
		c.last = 1'b1;
		send_char(c);
		wait_for_results();

		// Automatic base, unsigned: minus error, hex and octal prefixes, bare 0x.
		set_reg(REG_RADIX, RADIX_AUTO);
		set_reg(REG_SIGNED, 5'd0);
		send_text("-5", 1'b0);
		send_text("0xFf", 1'b0);
		send_text("077", 1'b0);
		send_text("0x", 1'b0);
		wait_for_results();

		for (int p = 0; p < PHASES; p++) begin
			idle_on = (p < PHASES - 2);
			set_reg(REG_RADIX, radix_plan[p]);
			set_reg(REG_SIGNED, (p % 3 != 1) ? 5'd1 : 5'd0);
			// The receiver holds off here while characters keep coming.
			if (p == 3)
				hold_token = hold_token + 1;
			start_chars = tracker.n_chars;
			while (tracker.n_chars - start_chars < PER_PHASE)
				random_string();
			wait_for_results();
		end

		$display("Sent %0d characters and checked %0d results over %0d register writes.",
			tracker.n_chars, tracker.n_results, n_reg_writes);
		$display("Settings covered automatic, 2, 8, 10, 16 and unsupported bases, both sign modes.");
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("ascii_integer_parser test passed");
		end else begin
			$display("ascii_integer_parser test failed");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/aip_pkg.sv
sv/aip_cfg.sv
sv/aip_core.sv
sv/ascii_integer_parser.sv
sv/aip_checker.sv
dv/ascii_integer_parser_tb.sv
